FILE: rtl/adts_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// ADTS deframer assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ADTS_FRAME_DEFRAMER_MACROS_SVH
`define ADTS_FRAME_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define AFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adts deframer assertion failed");
// Next-cycle implication
`define AFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adts deframer assertion failed");
`else
`define AFD_ASSERT_NOW(lbl, ante, cons)
`define AFD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/adts_fd_pkg.sv
// ---------------------------------------------------------------------------
// ADTS deframer package
// Shared types, codes and constants of the ADTS frame deframer.
// ---------------------------------------------------------------------------
package adts_fd_pkg;

    localparam int HEADER_BYTES = 7;
    localparam int LEN_W        = 13;
    localparam int HDR_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [LEN_W-1:0] HDR_LEN     = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 13'd5120;
    localparam logic [7:0]       SYNC_BYTE   = 8'hFF;
    localparam logic [3:0]       SYNC_NIBBLE = 4'hF;

    // result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LEN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRIP   = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             frame_first;
        logic             frame_last;
        logic [LEN_W-1:0] frame_length;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0] max_len;
        logic             strip;
    } t_cfg;

    // One command per input byte that causes results; all results of a
    // command share one frame length.
    typedef struct packed {
        logic                             hdr_emit;
        logic [HEADER_BYTES-1:0][7:0]     hdr_bytes;
        logic                             byte_emit;
        logic [7:0]                       data_byte;
        logic                             first;
        logic                             last;
        logic                             stat_emit;
        logic [1:0]                       stat;
        logic [LEN_W-1:0]                 length;
    } t_cmd;

endpackage

FILE: rtl/adts_fd_front.sv
// ---------------------------------------------------------------------------
// ADTS deframer front end
// Hunts for sync, collects the header and turns each byte that causes results into a command.
// ---------------------------------------------------------------------------
module adts_fd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  adts_fd_pkg::t_in_item i_item,
    input  adts_fd_pkg::t_cfg     i_cfg,
    input  logic                  i_q_full,
    output logic                  o_push,
    output adts_fd_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase                                r_phase, n_phase;
    logic [7:0]                            r_hdr [adts_fd_pkg::HEADER_BYTES];
    logic [adts_fd_pkg::HDR_IDX_W-1:0]     r_hcnt, n_hcnt;
    logic [adts_fd_pkg::LEN_W-1:0]         r_cur_len, n_cur_len;
    logic [adts_fd_pkg::LEN_W-1:0]         r_left, n_left;
    logic [adts_fd_pkg::LEN_W-1:0]         w_len;
    logic [adts_fd_pkg::HDR_IDX_W-1:0]     w_wr_idx;
    logic                                  w_wr;
    logic                                  w_acc;
    logic [7:0]                            w_b;
    adts_fd_pkg::t_cmd                     w_cmd;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_b     = i_item.in_byte;
    assign w_len   = {r_hdr[3][1:0], r_hdr[4], r_hdr[5][7:5]};

    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_cur_len = r_cur_len;
        n_left    = r_left;
        w_wr      = 1'b0;
        w_wr_idx  = r_hcnt;
        w_cmd     = '0;
        case (r_phase)
            PH_HUNT: begin
                if (w_b == adts_fd_pkg::SYNC_BYTE) begin
                    w_wr      = 1'b1;
                    w_wr_idx  = '0;
                    n_hcnt    = 3'd1;
                    n_cur_len = '0;
                    n_phase   = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (w_b[7:4] == adts_fd_pkg::SYNC_NIBBLE) begin
                    w_wr     = 1'b1;
                    w_wr_idx = 3'd1;
                    n_hcnt   = 3'd2;
                    n_phase  = PH_HEADER;
                end else begin
                    n_hcnt  = '0;
                    n_phase = PH_HUNT;
                end
            end
            PH_HEADER: begin
                w_wr   = 1'b1;
                n_hcnt = r_hcnt + 3'd1;
                if (r_hcnt == 3'(adts_fd_pkg::HEADER_BYTES - 1)) begin
                    // header complete: check the length and emit or drop
                    n_cur_len    = w_len;
                    n_hcnt       = '0;
                    w_cmd.length = w_len;
                    if (w_len < adts_fd_pkg::HDR_LEN) begin
                        w_cmd.stat_emit = 1'b1;
                        w_cmd.stat      = adts_fd_pkg::ST_SHORT;
                        n_phase         = PH_HUNT;
                    end else if (w_len > i_cfg.max_len) begin
                        w_cmd.stat_emit = 1'b1;
                        w_cmd.stat      = adts_fd_pkg::ST_LONG;
                        n_phase         = PH_HUNT;
                    end else begin
                        n_left = w_len - adts_fd_pkg::HDR_LEN;
                        if (!i_cfg.strip) begin
                            w_cmd.hdr_emit = 1'b1;
                            for (int k = 0; k < adts_fd_pkg::HEADER_BYTES - 1; k++) begin
                                w_cmd.hdr_bytes[k] = r_hdr[k];
                            end
                            w_cmd.hdr_bytes[adts_fd_pkg::HEADER_BYTES-1] = w_b;
                            w_cmd.last = (n_left == '0);
                        end
                        n_phase = (n_left == '0) ? PH_HUNT : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_left          = r_left - 13'd1;
                w_cmd.byte_emit = 1'b1;
                w_cmd.data_byte = w_b;
                w_cmd.first     = i_cfg.strip &&
                                  ((r_left + adts_fd_pkg::HDR_LEN) == r_cur_len);
                w_cmd.last      = (n_left == '0);
                w_cmd.length    = r_cur_len;
                if (n_left == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // end of data: report an unfinished frame and go back to hunting
        if (i_item.end_of_data) begin
            if (n_phase == PH_HEADER || n_phase == PH_PAYLOAD) begin
                w_cmd.stat_emit = 1'b1;
                w_cmd.stat      = adts_fd_pkg::ST_TRUNC;
                w_cmd.length    = (n_phase == PH_PAYLOAD) ? n_cur_len : '0;
            end
            n_phase = PH_HUNT;
            n_hcnt  = '0;
            n_left  = '0;
        end
    end

    assign o_push = w_acc && (w_cmd.hdr_emit || w_cmd.byte_emit || w_cmd.stat_emit);
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_hcnt    <= '0;
            r_cur_len <= '0;
            r_left    <= '0;
        end else if (w_acc) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_cur_len <= n_cur_len;
            r_left    <= n_left;
            if (w_wr) begin
                r_hdr[w_wr_idx] <= w_b;
            end
        end
    end

endmodule

FILE: rtl/adts_fd_queue.sv
// ---------------------------------------------------------------------------
// ADTS deframer command queue
// Short FIFO of commands between the front end and the result sequencer.
// ---------------------------------------------------------------------------
module adts_fd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  adts_fd_pkg::t_cmd i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output adts_fd_pkg::t_cmd o_data
);

    adts_fd_pkg::t_cmd                r_mem [adts_fd_pkg::QUEUE_DEPTH];
    logic [adts_fd_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [adts_fd_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = (r_cnt == (adts_fd_pkg::QPTR_W + 1)'(adts_fd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            // hold the count when both sides move
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/adts_fd_back.sv
// ---------------------------------------------------------------------------
// ADTS deframer result sequencer
// Expands commands into result items, one per cycle while the output slot is free, into an output register.
// ---------------------------------------------------------------------------
module adts_fd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  adts_fd_pkg::t_cmd      i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output adts_fd_pkg::t_out_item o_item
);

    adts_fd_pkg::t_cmd                 r_cmd, w_cur;
    logic                              r_hp, r_bp, r_sp;
    logic [adts_fd_pkg::HDR_IDX_W-1:0] r_idx, w_idx, n_idx;
    logic                              w_h, w_b, w_s, n_hp, n_bp, n_sp;
    logic                              w_any, w_adv, w_emit;
    logic                              r_ovalid;
    adts_fd_pkg::t_out_item            r_out, n_out;

    // work from the held command, else straight from the queue head
    assign w_any  = r_hp || r_bp || r_sp;
    assign w_cur  = w_any ? r_cmd : i_q_data;
    assign w_h    = w_any ? r_hp : i_q_data.hdr_emit;
    assign w_b    = w_any ? r_bp : i_q_data.byte_emit;
    assign w_s    = w_any ? r_sp : i_q_data.stat_emit;
    assign w_idx  = w_any ? r_idx : '0;
    assign w_adv  = !r_ovalid || i_ready;
    assign w_emit = w_adv && (w_any || i_q_valid);
    assign o_pop  = w_emit && !w_any;

    always_comb begin
        n_out              = '0;
        n_out.frame_length = w_cur.length;
        n_hp               = w_h;
        n_bp               = w_b;
        n_sp               = w_s;
        n_idx              = w_idx;
        if (w_h) begin
            n_out.out_byte    = w_cur.hdr_bytes[w_idx];
            n_out.frame_first = (w_idx == '0);
            n_out.frame_last  = (w_idx == 3'(adts_fd_pkg::HEADER_BYTES - 1)) && w_cur.last;
            n_out.status      = adts_fd_pkg::ST_BYTE;
            n_idx             = w_idx + 3'd1;
            n_hp              = (w_idx != 3'(adts_fd_pkg::HEADER_BYTES - 1));
        end else if (w_b) begin
            n_out.out_byte    = w_cur.data_byte;
            n_out.frame_first = w_cur.first;
            n_out.frame_last  = w_cur.last;
            n_out.status      = adts_fd_pkg::ST_BYTE;
            n_bp              = 1'b0;
        end else begin
            n_out.status = w_cur.stat;
            n_sp         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp     <= 1'b0;
            r_bp     <= 1'b0;
            r_sp     <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_hp     <= n_hp;
            r_bp     <= n_bp;
            r_sp     <= n_sp;
            r_idx    <= n_idx;
            r_cmd    <= w_cur;
            r_out    <= n_out;
            r_ovalid <= 1'b1;
        end else if (w_adv) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule

FILE: rtl/adts_frame_deframer.sv
// Path: a byte's command enters the command queue when the byte transfers; the sequencer
//   then loads the results into the output register; a header burst gives seven results.
// Throughput: one input byte per cycle while the queue has room; the four-entry command queue
//   takes four payload bytes during a header burst, then input holds while the burst drains.
// Reset: i_rst_n synchronous, active low; returns to hunting for sync with an empty queue,
//   max_frame_length = 5120 and strip_header = 0.
// ---------------------------------------------------------------------------
// ADTS frame deframer
// Finds ADTS frames in a byte stream, passes on header (unless stripped) and payload bytes, and reports statuses.
// ---------------------------------------------------------------------------
`include "adts_frame_deframer_macros.svh"

module adts_frame_deframer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input byte channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  adts_fd_pkg::t_in_item                 i_in_item,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output adts_fd_pkg::t_out_item                o_out_item,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [adts_fd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [adts_fd_pkg::LEN_W-1:0]         i_cfg_data
);

    // Configuration registers. Writes must land only while the block is idle (the block does not
    // enforce it), so the front end may read them without any shadowing.
    adts_fd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len <= adts_fd_pkg::MAX_LEN_RST;
            r_cfg.strip   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                adts_fd_pkg::CFG_MAX_LEN: r_cfg.max_len <= i_cfg_data;
                adts_fd_pkg::CFG_STRIP:   r_cfg.strip   <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front end to queue: one command per transfer that causes results.
    logic              w_push;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_pop;
    adts_fd_pkg::t_cmd w_push_cmd;
    adts_fd_pkg::t_cmd w_head_cmd;

    // Front end: sync hunt, header capture, length check, end-of-data handling.
    // Ready drops only when the command queue is full.
    adts_fd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // Decouple the two sides so a stalled consumer does not stall byte intake
    // until the queue fills.
    adts_fd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head_cmd)
    );

    // Back end: expand each command (header burst, payload byte, status) into
    // the registered result channel; advance whenever the output slot frees.
    adts_fd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_head_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

    // A command is never written into a full queue.
    `AFD_ASSERT_NOW(a_no_overflow, w_push, !w_q_full)
    // A pop only happens when the queue holds a command.
    `AFD_ASSERT_NOW(a_no_underflow, w_pop, w_q_valid)
    // Status-only results carry no byte and no frame marks.
    `AFD_ASSERT_NOW(a_status_clean, o_out_valid && (o_out_item.status != adts_fd_pkg::ST_BYTE),
        (o_out_item.out_byte == 8'd0) && !o_out_item.frame_first && !o_out_item.frame_last)

endmodule
